[design/gwm_pkg.sv]
// ============================================================================
// gwm_pkg
// Shared types and constants for the glob wildcard matcher: item formats,
// operation and cell kind codes, and the links that join the cell row.
// ============================================================================
package gwm_pkg;

   localparam int GWM_CELLS_DEFAULT = 64;

   localparam logic [7:0] CHAR_STAR      = 8'h2A;
   localparam logic [7:0] CHAR_QUESTION  = 8'h3F;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_APPEND  = 2'd1,
      OP_SUBJECT = 2'd2,
      OP_END     = 2'd3
   } gwm_op_type;

   typedef enum logic [1:0] {
      KIND_LITERAL = 2'd0,
      KIND_ONE     = 2'd1,
      KIND_RUN     = 2'd2
   } gwm_kind_type;

   typedef struct packed {
      gwm_op_type operation;
      logic [7:0] character;
   } gwm_req_type;

   typedef struct packed {
      logic matched;
      logic pattern_overflow;
   } gwm_rsp_type;

   // Broadcast from the top level to every cell.
   typedef struct packed {
      logic         clear;
      logic         load;
      logic         restart;
      logic         step;
      gwm_kind_type kind;
      logic [7:0]   pat_char;
      logic [7:0]   subj_char;
   } gwm_ctrl_type;

   // Handed from each cell to its right-hand neighbor.
   typedef struct packed {
      logic head;
      logic valid;
      logic run_fwd;
      logic fwd;
   } gwm_link_type;

endpackage

[design/gwm_cell.sv]
// ============================================================================
// gwm_cell
// One pattern cell: holds a pattern element and the active flag of the
// position in front of it, and hands match progress to its neighbor.
// ============================================================================
module gwm_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  gwm_pkg::gwm_ctrl_type ctrl,
   input  gwm_pkg::gwm_link_type link_in,
   output gwm_pkg::gwm_link_type link_out,
   output logic                  end_hit
);

   logic                  valid_ff, valid_in;
   logic                  act_ff, act_in;
   gwm_pkg::gwm_kind_type kind_ff, kind_in;
   logic [7:0]            char_ff, char_in;

   logic closed;
   logic is_run;
   logic is_one;
   logic is_match;
   logic take;

   always_comb begin
      closed   = act_ff | link_in.run_fwd;
      is_run   = valid_ff && (kind_ff == gwm_pkg::KIND_RUN);
      is_one   = valid_ff && (kind_ff == gwm_pkg::KIND_ONE);
      is_match = valid_ff && (kind_ff == gwm_pkg::KIND_LITERAL) &&
                 (char_ff == ctrl.subj_char);
      take     = ctrl.load && link_in.valid && !valid_ff;

      link_out.head    = 1'b0;
      link_out.valid   = valid_ff;
      link_out.run_fwd = act_ff & is_run;
      link_out.fwd     = closed & (is_one | is_match);
      end_hit          = closed & !valid_ff & link_in.valid;

      valid_in = valid_ff;
      kind_in  = kind_ff;
      char_in  = char_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (take) begin
         valid_in = 1'b1;
         kind_in  = ctrl.kind;
         char_in  = ctrl.pat_char;
      end

      act_in = act_ff;
      if (ctrl.restart) begin
         act_in = link_in.head;
      end else if (ctrl.step) begin
         act_in = (closed & is_run) | link_in.fwd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         act_ff   <= link_in.head;
      end else begin
         valid_ff <= valid_in;
         act_ff   <= act_in;
      end
      kind_ff <= kind_in;
      char_ff <= char_in;
   end

endmodule

[design/glob_wildcard_match_top.sv]
// ============================================================================
// glob_wildcard_match_top
// Glob matcher with '*', '?' and backslash escapes over a row of cells,
// case-insensitive for ASCII letters.
// ============================================================================
// Takes one item every cycle: clear, pattern append, subject byte or end of
// subject. A subject byte moves the active positions one step through the
// whole cell row in that cycle, so the row width sets no rate limit. Only an
// end-of-subject item gives a result; results wait in an output register
// backed by one skid entry, and req_ready drops only while both hold an
// untaken result. Runs of unescaped stars share one cell, but each still
// counts against PATTERN_CELLS for the overflow flag.
module glob_wildcard_match_top #(
   parameter int PATTERN_CELLS = gwm_pkg::GWM_CELLS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  gwm_pkg::gwm_req_type req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output gwm_pkg::gwm_rsp_type rsp_item
);

   localparam int CW = $clog2(PATTERN_CELLS + 1);

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

   logic [CW-1:0] count_ff, count_in;
   logic          pending_ff, pending_in;
   logic          overflow_ff, overflow_in;
   logic          last_run_ff, last_run_in;
   logic          a_end_ff, a_end_in;

   logic                 rsp_valid_ff;
   gwm_pkg::gwm_rsp_type rsp_item_ff;
   logic                 skid_valid_ff;
   gwm_pkg::gwm_rsp_type skid_item_ff;

   gwm_pkg::gwm_ctrl_type          ctrl;
   gwm_pkg::gwm_link_type          links [0:PATTERN_CELLS];
   logic [PATTERN_CELLS-1:0]       hits;
   logic                           accept;
   logic                           new_rsp;
   logic                           end_hit;
   logic                           need_cell;
   logic                           full;
   gwm_pkg::gwm_rsp_type           new_item;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign links[0] = '{head: 1'b1, valid: 1'b1, run_fwd: 1'b0, fwd: 1'b0};

   genvar gi;
   generate
      for (gi = 0; gi < PATTERN_CELLS; gi++) begin : g_cell
         gwm_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .link_in  (links[gi]),
            .link_out (links[gi+1]),
            .end_hit  (hits[gi])
         );
      end
   endgenerate

   assign end_hit = (|hits) |
                    (links[PATTERN_CELLS].valid &
                     (a_end_ff | links[PATTERN_CELLS].run_fwd));

   always_comb begin
      full        = (count_ff == CW'(PATTERN_CELLS));
      need_cell   = 1'b0;
      count_in    = count_ff;
      pending_in  = pending_ff;
      overflow_in = overflow_ff;
      last_run_in = last_run_ff;

      ctrl           = '0;
      ctrl.kind      = gwm_pkg::KIND_LITERAL;
      ctrl.pat_char  = fold_case(req_item.character);
      ctrl.subj_char = fold_case(req_item.character);

      if (accept) begin
         case (req_item.operation)
            gwm_pkg::OP_CLEAR: begin
               ctrl.clear   = 1'b1;
               ctrl.restart = 1'b1;
               count_in     = '0;
               pending_in   = 1'b0;
               overflow_in  = 1'b0;
               last_run_in  = 1'b0;
            end
            gwm_pkg::OP_APPEND: begin
               ctrl.restart = 1'b1;
               if (pending_ff) begin
                  pending_in = 1'b0;
                  need_cell  = 1'b1;
               end else if (req_item.character == gwm_pkg::CHAR_BACKSLASH) begin
                  pending_in = 1'b1;
               end else if (req_item.character == gwm_pkg::CHAR_STAR) begin
                  ctrl.kind = gwm_pkg::KIND_RUN;
                  need_cell = 1'b1;
               end else if (req_item.character == gwm_pkg::CHAR_QUESTION) begin
                  ctrl.kind = gwm_pkg::KIND_ONE;
                  need_cell = 1'b1;
               end else begin
                  need_cell = 1'b1;
               end
               if (need_cell) begin
                  if (full) begin
                     overflow_in = 1'b1;
                  end else begin
                     count_in = count_ff + 1'b1;
                     if (!(ctrl.kind == gwm_pkg::KIND_RUN && last_run_ff)) begin
                        ctrl.load   = 1'b1;
                        last_run_in = (ctrl.kind == gwm_pkg::KIND_RUN);
                     end
                  end
               end
            end
            gwm_pkg::OP_SUBJECT: begin
               ctrl.step = 1'b1;
            end
            gwm_pkg::OP_END: begin
               ctrl.restart = 1'b1;
            end
            default: begin
               ctrl.step = 1'b0;
            end
         endcase
      end

      a_end_in = a_end_ff;
      if (ctrl.restart) begin
         a_end_in = 1'b0;
      end else if (ctrl.step) begin
         a_end_in = links[PATTERN_CELLS].fwd;
      end

      new_rsp                   = accept && (req_item.operation == gwm_pkg::OP_END);
      new_item.matched          = end_hit;
      new_item.pattern_overflow = overflow_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pending_ff    <= 1'b0;
         overflow_ff   <= 1'b0;
         last_run_ff   <= 1'b0;
         a_end_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         pending_ff  <= pending_in;
         overflow_ff <= overflow_in;
         last_run_ff <= last_run_in;
         a_end_ff    <= a_end_in;
         if (!rsp_valid_ff || rsp_ready) begin
            if (skid_valid_ff) begin
               rsp_item_ff   <= skid_item_ff;
               rsp_valid_ff  <= 1'b1;
               skid_valid_ff <= new_rsp;
               skid_item_ff  <= new_item;
            end else begin
               rsp_valid_ff <= new_rsp;
               rsp_item_ff  <= new_item;
            end
         end else if (new_rsp) begin
            skid_valid_ff <= 1'b1;
            skid_item_ff  <= new_item;
         end
      end
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held while output register empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(PATTERN_CELLS))
      else $error("pattern count past capacity");

   a_clear_resets: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.operation == gwm_pkg::OP_CLEAR) |=>
         (count_ff == '0) && !overflow_ff && !pending_ff)
      else $error("clear item left pattern state behind");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      $rose(overflow_ff) |-> (count_ff == CW'(PATTERN_CELLS)))
      else $error("overflow flagged with free cells");

endmodule
